// ===== hw/rtl/fbar_pkg.sv =====
package fbar_pkg;

    localparam int FLARE_COUNT_DEF = 256;

    localparam logic [31:0] TEST_MS   = 32'd20;
    localparam logic [31:0] STALE_MS  = 32'd500;
    localparam logic [8:0]  RAMP_UP   = 9'd8;
    localparam logic [8:0]  RAMP_DOWN = 9'd38;
    localparam logic [8:0]  ALPHA_MAX = 9'd192;

    localparam logic [28:0] FADE_BASE = 29'd419430;
    localparam logic [28:0] FADE_ONE  = 29'd4194304;

    // floor(x / 32000) == floor(floor(x / 256) / 125); 1/125 as floor(2^36 / 125)
    localparam logic [29:0] RECIP_125 = 30'd549755813;
    localparam logic [29:0] DIV_125   = 30'd125;

    localparam logic [2:0] CFG_FLARES_ON   = 3'd0;
    localparam logic [2:0] CFG_INTENSITY   = 3'd1;
    localparam logic [2:0] CFG_VIEW_ORIGIN = 3'd2;
    localparam logic [2:0] CFG_RIGHT_AXIS  = 3'd3;
    localparam logic [2:0] CFG_UP_AXIS     = 3'd4;

    typedef struct packed {
        logic signed [19:0] org_x;
        logic signed [19:0] org_y;
        logic signed [19:0] org_z;
        logic [15:0]        radius;
        logic [23:0]        color;
        logic [7:0]         alpha;
    } side_t;

    typedef struct packed {
        logic [3:0][2:0][19:0] vtx;
        logic [23:0]           color;
        logic [7:0]            alpha;
    } hold_t;

    // round half up from Q.18 to Q.4, saturate to 20 bits
    function automatic logic [19:0] to_vertex(input logic signed [42:0] p);
        logic signed [42:0] t;
        logic signed [28:0] r;
        begin
            t = p + 43'sd8192;
            r = 29'(t >>> 14);
            if (r > 29'sd524287)
                to_vertex = 20'h7FFFF;
            else if (r < -29'sd524288)
                to_vertex = 20'h80000;
            else
                to_vertex = r[19:0];
        end
    endfunction

endpackage

// ===== hw/rtl/fbar_store.sv =====
module fbar_store #(
    parameter int FLARE_COUNT = fbar_pkg::FLARE_COUNT_DEF,
    parameter int IW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_idx,
    input  logic          s1_valid,
    input  logic [IW-1:0] s1_idx,
    input  logic          s1_vis,
    input  logic [31:0]   s1_now,
    output logic [7:0]    alpha_new,
    output logic          busy
);

    logic [39:0]   mem [FLARE_COUNT];
    logic [39:0]   rd_data_reg;
    logic [39:0]   fwd_data_reg;
    logic          fwd_hit_reg;
    logic [IW-1:0] clr_cnt_reg;
    logic          clr_busy_reg;

    logic [39:0]   entry;
    logic [31:0]   elapsed;
    logic          test;
    logic [8:0]    a_base;
    logic [8:0]    a_calc;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [39:0]   wr_data;

    always_comb
    begin
        entry   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        elapsed = s1_now - entry[39:8];
        test    = elapsed > fbar_pkg::TEST_MS;
        a_base  = (elapsed > fbar_pkg::STALE_MS) ? 9'd0 : {1'b0, entry[7:0]};
        if (s1_vis)
        begin
            a_calc = a_base + fbar_pkg::RAMP_UP;
            if (a_calc > fbar_pkg::ALPHA_MAX)
                a_calc = fbar_pkg::ALPHA_MAX;
        end
        else
        begin
            if (a_base < fbar_pkg::RAMP_DOWN)
                a_calc = 9'd0;
            else
                a_calc = a_base - fbar_pkg::RAMP_DOWN;
        end
        alpha_new = test ? a_calc[7:0] : entry[7:0];
        wr_en     = clr_busy_reg | (adv & s1_valid & test);
        wr_idx    = clr_busy_reg ? clr_cnt_reg : s1_idx;
        wr_data   = clr_busy_reg ? 40'd0 : {s1_now, a_calc[7:0]};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_idx];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg  <= 1'b0;
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            if (rd_en)
                fwd_hit_reg <= wr_en && (wr_idx == rd_idx);
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IW'(FLARE_COUNT - 1))
                    clr_busy_reg <= 1'b0;
            end
        end
    end

    assign busy = clr_busy_reg;

endmodule

// ===== hw/rtl/fbar_geom.sv =====
module fbar_geom (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  fbar_pkg::side_t     in_side,
    input  logic signed [15:0]  in_nrm_x,
    input  logic signed [15:0]  in_nrm_y,
    input  logic signed [15:0]  in_nrm_z,
    input  logic [11:0]         intensity,
    input  logic [59:0]         view_origin,
    input  logic [47:0]         right_axis,
    input  logic [47:0]         up_axis,
    output logic                out_valid,
    output fbar_pkg::hold_t     out_hold
);

    localparam int SQ_N = 21;
    localparam int DV_N = 16;

    // view vector
    logic                  g1_valid_reg;
    logic signed [20:0]    g1_v_reg [3];
    logic signed [15:0]    g1_n_reg [3];
    fbar_pkg::side_t       g1_side_reg;
    logic signed [20:0]    g1_v_next [3];
    logic signed [19:0]    org_a [3];

    always_comb
    begin
        org_a[0] = in_side.org_x;
        org_a[1] = in_side.org_y;
        org_a[2] = in_side.org_z;
        for (int i = 0; i < 3; i++)
            g1_v_next[i] = 21'(org_a[i]) - 21'($signed(view_origin[20*i +: 20]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g1_valid_reg <= 1'b0;
        else if (adv)
            g1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_v_reg    <= g1_v_next;
            g1_n_reg[0] <= in_nrm_x;
            g1_n_reg[1] <= in_nrm_y;
            g1_n_reg[2] <= in_nrm_z;
            g1_side_reg <= in_side;
        end
    end

    // squares and normal products
    logic                  g2_valid_reg;
    logic [40:0]           g2_sq_reg [3];
    logic signed [36:0]    g2_pr_reg [3];
    fbar_pkg::side_t       g2_side_reg;
    logic [40:0]           g2_sq_next [3];
    logic signed [36:0]    g2_pr_next [3];
    logic signed [41:0]    vw [3];
    logic signed [41:0]    sqw [3];
    logic signed [36:0]    vn [3];
    logic signed [36:0]    nn [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vw[i]         = 42'(g1_v_reg[i]);
            sqw[i]        = vw[i] * vw[i];
            g2_sq_next[i] = sqw[i][40:0];
            vn[i]         = 37'(g1_v_reg[i]);
            nn[i]         = 37'(g1_n_reg[i]);
            g2_pr_next[i] = vn[i] * nn[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g2_valid_reg <= 1'b0;
        else if (adv)
            g2_valid_reg <= g1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g2_sq_reg   <= g2_sq_next;
            g2_pr_reg   <= g2_pr_next;
            g2_side_reg <= g1_side_reg;
        end
    end

    // square root, one result bit per stage; entry 0 holds the sums
    logic                  sq_valid_reg [SQ_N+1];
    logic [41:0]           sq_rem_reg   [SQ_N+1];
    logic [42:0]           sq_res_reg   [SQ_N+1];
    logic signed [38:0]    sq_dot_reg   [SQ_N+1];
    fbar_pkg::side_t       sq_side_reg  [SQ_N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (adv)
            sq_valid_reg[0] <= g2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0]  <= 42'(g2_sq_reg[0]) + 42'(g2_sq_reg[1]) + 42'(g2_sq_reg[2]);
            sq_res_reg[0]  <= '0;
            sq_dot_reg[0]  <= 39'(g2_pr_reg[0]) + 39'(g2_pr_reg[1]) + 39'(g2_pr_reg[2]);
            sq_side_reg[0] <= g2_side_reg;
        end
    end

    for (genvar s = 0; s < SQ_N; s++)
    begin : g_sqrt
        localparam logic [42:0] BIT = 43'(1) << (2 * (SQ_N - 1 - s));
        logic [42:0] sum;
        logic        take;

        always_comb
        begin
            sum  = sq_res_reg[s] + BIT;
            take = {1'b0, sq_rem_reg[s]} >= sum;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[s+1] <= 1'b0;
            else if (adv)
                sq_valid_reg[s+1] <= sq_valid_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[s+1]  <= take ? 42'({1'b0, sq_rem_reg[s]} - sum) : sq_rem_reg[s];
                sq_res_reg[s+1]  <= take ? (sq_res_reg[s] >> 1) + BIT : sq_res_reg[s] >> 1;
                sq_dot_reg[s+1]  <= sq_dot_reg[s];
                sq_side_reg[s+1] <= sq_side_reg[s];
            end
        end
    end

    // cull, numerator, radius*dist
    logic                  z1_valid_reg;
    logic [20:0]           z1_dist_reg;
    logic [38:0]           z1_num_reg;
    logic [36:0]           z1_rd_reg;
    fbar_pkg::side_t       z1_side_reg;
    logic [20:0]           dist_w;
    logic                  keep;
    logic [38:0]           z1_num_next;

    always_comb
    begin
        dist_w      = sq_res_reg[SQ_N][20:0];
        keep        = (dist_w == '0) || (sq_dot_reg[SQ_N] <= 39'sd0);
        z1_num_next = (dist_w == '0) ? '0 : 39'(-sq_dot_reg[SQ_N]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            z1_valid_reg <= 1'b0;
        else if (adv)
            z1_valid_reg <= sq_valid_reg[SQ_N] && keep;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z1_dist_reg <= dist_w;
            z1_num_reg  <= z1_num_next;
            z1_rd_reg   <= 37'(sq_side_reg[SQ_N].radius) * 37'(dist_w);
            z1_side_reg <= sq_side_reg[SQ_N];
        end
    end

    // divide by 32000 through a reciprocal
    logic                  z2_valid_reg;
    logic [28:0]           z2_y_reg;
    logic [58:0]           z2_prod_reg;
    logic [20:0]           z2_dist_reg;
    logic [38:0]           z2_num_reg;
    fbar_pkg::side_t       z2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            z2_valid_reg <= 1'b0;
        else if (adv)
            z2_valid_reg <= z1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z2_y_reg    <= z1_rd_reg[36:8];
            z2_prod_reg <= 59'(z1_rd_reg[36:8]) * 59'(fbar_pkg::RECIP_125);
            z2_dist_reg <= z1_dist_reg;
            z2_num_reg  <= z1_num_reg;
            z2_side_reg <= z1_side_reg;
        end
    end

    logic                  z3_valid_reg;
    logic [22:0]           z3_q_reg;
    logic [7:0]            z3_r_reg;
    logic [20:0]           z3_dist_reg;
    logic [38:0]           z3_num_reg;
    fbar_pkg::side_t       z3_side_reg;
    logic [22:0]           qe;
    logic [29:0]           rem_w;

    always_comb
    begin
        qe    = z2_prod_reg[58:36];
        rem_w = 30'(z2_y_reg) - 30'(qe) * fbar_pkg::DIV_125;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            z3_valid_reg <= 1'b0;
        else if (adv)
            z3_valid_reg <= z2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z3_q_reg    <= qe;
            z3_r_reg    <= rem_w[7:0];
            z3_dist_reg <= z2_dist_reg;
            z3_num_reg  <= z2_num_reg;
            z3_side_reg <= z2_side_reg;
        end
    end

    // half-size; entry 0 of the divider
    logic                  dv_valid_reg [DV_N+1];
    logic [38:0]           dv_rem_reg   [DV_N+1];
    logic [15:0]           dv_q_reg     [DV_N+1];
    logic [20:0]           dv_dist_reg  [DV_N+1];
    logic [22:0]           dv_size_reg  [DV_N+1];
    fbar_pkg::side_t       dv_side_reg  [DV_N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= z3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0]  <= z3_num_reg;
            dv_q_reg[0]    <= '0;
            dv_dist_reg[0] <= z3_dist_reg;
            dv_size_reg[0] <= 23'(z3_side_reg.radius) + z3_q_reg
                              + 23'(z3_r_reg >= fbar_pkg::DIV_125[7:0]);
            dv_side_reg[0] <= z3_side_reg;
        end
    end

    for (genvar s = 0; s < DV_N; s++)
    begin : g_div
        localparam int K = DV_N - 1 - s;
        logic [39:0] sub;
        logic        take;

        // zero distance keeps the quotient at zero
        always_comb
        begin
            sub  = 40'(dv_dist_reg[s]) << K;
            take = (dv_dist_reg[s] != '0) && ({1'b0, dv_rem_reg[s]} >= sub);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[s+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[s+1] <= dv_valid_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[s+1]  <= take ? 39'({1'b0, dv_rem_reg[s]} - sub) : dv_rem_reg[s];
                dv_q_reg[s+1]    <= dv_q_reg[s] | (16'(take) << K);
                dv_dist_reg[s+1] <= dv_dist_reg[s];
                dv_size_reg[s+1] <= dv_size_reg[s];
                dv_side_reg[s+1] <= dv_side_reg[s];
            end
        end
    end

    // angle fade
    logic                  f1_valid_reg;
    logic [28:0]           f1_fade_reg;
    logic [22:0]           f1_size_reg;
    fbar_pkg::side_t       f1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (adv)
            f1_valid_reg <= dv_valid_reg[DV_N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_fade_reg <= 29'(dv_q_reg[DV_N]) * 29'(intensity) + fbar_pkg::FADE_BASE;
            f1_size_reg <= dv_size_reg[DV_N];
            f1_side_reg <= dv_side_reg[DV_N];
        end
    end

    // alpha scale and corner offsets
    logic                  f2_valid_reg;
    logic [7:0]            f2_alpha_reg;
    logic signed [40:0]    f2_pu_reg [3];
    logic signed [40:0]    f2_pd_reg [3];
    fbar_pkg::side_t       f2_side_reg;
    logic [22:0]           fade;
    logic [30:0]           am;
    logic signed [40:0]    sz_s;
    logic signed [40:0]    su [3];
    logic signed [40:0]    sd [3];
    logic signed [40:0]    f2_pu_next [3];
    logic signed [40:0]    f2_pd_next [3];

    always_comb
    begin
        fade = (f1_fade_reg > fbar_pkg::FADE_ONE) ? fbar_pkg::FADE_ONE[22:0] : f1_fade_reg[22:0];
        am   = 31'(f1_side_reg.alpha) * 31'(fade);
        sz_s = $signed({18'd0, f1_size_reg});
        for (int i = 0; i < 3; i++)
        begin
            su[i] = 41'($signed(up_axis[16*i +: 16])) + 41'($signed(right_axis[16*i +: 16]));
            sd[i] = 41'($signed(right_axis[16*i +: 16])) - 41'($signed(up_axis[16*i +: 16]));
            f2_pu_next[i] = su[i] * sz_s;
            f2_pd_next[i] = sd[i] * sz_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_valid_reg <= 1'b0;
        else if (adv)
            f2_valid_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_alpha_reg <= am[29:22];
            f2_pu_reg    <= f2_pu_next;
            f2_pd_reg    <= f2_pd_next;
            f2_side_reg  <= f1_side_reg;
        end
    end

    // corner vertices
    logic                  h_valid_reg;
    fbar_pkg::hold_t       h_reg;
    fbar_pkg::hold_t       h_next;
    logic signed [42:0]    base [3];
    logic signed [19:0]    org_b [3];

    always_comb
    begin
        org_b[0] = f2_side_reg.org_x;
        org_b[1] = f2_side_reg.org_y;
        org_b[2] = f2_side_reg.org_z;
        for (int i = 0; i < 3; i++)
        begin
            base[i] = 43'(org_b[i]) <<< 14;
            h_next.vtx[0][i] = fbar_pkg::to_vertex(base[i] - 43'(f2_pd_reg[i]));
            h_next.vtx[1][i] = fbar_pkg::to_vertex(base[i] + 43'(f2_pu_reg[i]));
            h_next.vtx[2][i] = fbar_pkg::to_vertex(base[i] + 43'(f2_pd_reg[i]));
            h_next.vtx[3][i] = fbar_pkg::to_vertex(base[i] - 43'(f2_pu_reg[i]));
        end
        h_next.color = f2_side_reg.color;
        h_next.alpha = f2_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (adv)
            h_valid_reg <= f2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            h_reg <= h_next;
    end

    assign out_valid = h_valid_reg;
    assign out_hold  = h_reg;

endmodule

// ===== hw/rtl/flare_billboard_alpha_ramp.sv =====
// Flare billboard generator with a per-flare alpha ramp.
// Input stream (s_*): one word per flare; tdata carries index, origin, normal,
// radius, color, visible bit and time in milliseconds.
// Output stream (m_*): four words per flare, one per quad corner, tuser is the
// corner number and tlast marks corner 3. Culled flares give no words.
// Config channel (cfg_*): register index and data; always ready. Write only
// while the block is idle.
// Throughput: one corner word per cycle while m_tready is high, four words per
// flare; the output hold stage releases the pipeline only as its fourth corner leaves.
// The square root and divider are one bit per stage, fully pipelined.
// The alpha/time store is one synchronous memory read at input accept and written
// as the flare leaves the input register if its test interval has passed, with forwarding between back-to-back flares.
// Reset: a clearing pass writes every store entry with s_tready low.
// Registers return to flares_on=1, intensity=256, axes zero.
// When a corner word waits with m_tready low, the whole pipeline holds and
// s_tready drops.
module flare_billboard_alpha_ramp #(
    parameter int FLARE_COUNT = fbar_pkg::FLARE_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // idx[7:0] ox[27:8] oy[47:28] oz[67:48] nx[83:68] ny[99:84] nz[115:100]
    // radius[131:116] color[155:132] visible[156] now_ms[188:157]
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vx[19:0] vy[39:20] vz[59:40] color[83:60] alpha[91:84]
    output logic [95:0]  m_tdata,
    // corner[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [59:0]  cfg_data
);

    localparam int IW = (FLARE_COUNT > 1) ? $clog2(FLARE_COUNT) : 1;

    logic        flares_on_reg;
    logic [11:0] intensity_reg;
    logic [59:0] view_origin_reg;
    logic [47:0] right_axis_reg;
    logic [47:0] up_axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flares_on_reg   <= 1'b1;
            intensity_reg   <= 12'd256;
            view_origin_reg <= '0;
            right_axis_reg  <= '0;
            up_axis_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fbar_pkg::CFG_FLARES_ON:   flares_on_reg   <= cfg_data[0];
                fbar_pkg::CFG_INTENSITY:   intensity_reg   <= cfg_data[11:0];
                fbar_pkg::CFG_VIEW_ORIGIN: view_origin_reg <= cfg_data;
                fbar_pkg::CFG_RIGHT_AXIS:  right_axis_reg  <= cfg_data[47:0];
                fbar_pkg::CFG_UP_AXIS:     up_axis_reg     <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic          adv;
    logic          busy;
    logic          accept;
    logic          h_valid;
    fbar_pkg::hold_t hold;
    logic [1:0]    corner_reg;
    logic [IW-1:0] fold_tab [256];
    logic [IW-1:0] in_idx;

    for (genvar g = 0; g < 256; g++)
    begin : g_fold
        assign fold_tab[g] = IW'(g % FLARE_COUNT);
    end

    assign in_idx   = fold_tab[s_tdata[7:0]];
    assign adv      = !h_valid || (m_tready && (corner_reg == 2'd3));
    assign s_tready = adv && !busy;
    assign accept   = s_tvalid && s_tready;

    logic               s1_valid_reg;
    logic [IW-1:0]      s1_idx_reg;
    logic signed [19:0] s1_org_reg [3];
    logic signed [15:0] s1_nrm_reg [3];
    logic [15:0]        s1_radius_reg;
    logic [23:0]        s1_color_reg;
    logic               s1_vis_reg;
    logic [31:0]        s1_now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept && flares_on_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg    <= in_idx;
            s1_org_reg[0] <= s_tdata[27:8];
            s1_org_reg[1] <= s_tdata[47:28];
            s1_org_reg[2] <= s_tdata[67:48];
            s1_nrm_reg[0] <= s_tdata[83:68];
            s1_nrm_reg[1] <= s_tdata[99:84];
            s1_nrm_reg[2] <= s_tdata[115:100];
            s1_radius_reg <= s_tdata[131:116];
            s1_color_reg  <= s_tdata[155:132];
            s1_vis_reg    <= s_tdata[156];
            s1_now_reg    <= s_tdata[188:157];
        end
    end

    logic [7:0]      alpha_new;
    fbar_pkg::side_t s1_side;

    fbar_store #(
        .FLARE_COUNT (FLARE_COUNT),
        .IW          (IW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .rd_en     (accept),
        .rd_idx    (in_idx),
        .s1_valid  (s1_valid_reg),
        .s1_idx    (s1_idx_reg),
        .s1_vis    (s1_vis_reg),
        .s1_now    (s1_now_reg),
        .alpha_new (alpha_new),
        .busy      (busy)
    );

    always_comb
    begin
        s1_side.org_x  = s1_org_reg[0];
        s1_side.org_y  = s1_org_reg[1];
        s1_side.org_z  = s1_org_reg[2];
        s1_side.radius = s1_radius_reg;
        s1_side.color  = s1_color_reg;
        s1_side.alpha  = alpha_new;
    end

    fbar_geom u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (s1_valid_reg),
        .in_side     (s1_side),
        .in_nrm_x    (s1_nrm_reg[0]),
        .in_nrm_y    (s1_nrm_reg[1]),
        .in_nrm_z    (s1_nrm_reg[2]),
        .intensity   (intensity_reg),
        .view_origin (view_origin_reg),
        .right_axis  (right_axis_reg),
        .up_axis     (up_axis_reg),
        .out_valid   (h_valid),
        .out_hold    (hold)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            corner_reg <= 2'd0;
        else if (h_valid && m_tready)
            corner_reg <= corner_reg + 2'd1;
    end

    assign m_tvalid = h_valid;
    assign m_tdata  = {4'd0, hold.alpha, hold.color, hold.vtx[corner_reg][2],
                       hold.vtx[corner_reg][1], hold.vtx[corner_reg][0]};
    assign m_tuser  = corner_reg;
    assign m_tlast  = (corner_reg == 2'd3);

endmodule

// ===== hw/rtl/fbar_checker.sv =====
module fbar_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
        else $error("tlast does not match corner 3");

    a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tuser == 2'($past(m_tuser) + 2'd1))))
        else $error("corner sequence broken");

    a_same_flare: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> $stable(m_tdata[91:60]))
        else $error("color or alpha changed within a flare");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled word changed");

endmodule

bind flare_billboard_alpha_ramp fbar_checker u_fbar_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/tb_flare_billboard_alpha_ramp.sv =====
module tb_flare_billboard_alpha_ramp;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_UNUSED = 3'd6;
    localparam int         DRAIN_CYCLES = 80;

    typedef struct {
        logic [7:0]         idx;
        logic signed [19:0] ox, oy, oz;
        logic signed [15:0] nx, ny, nz;
        logic [15:0]        radius;
        logic [23:0]        color;
        logic               vis;
        logic [31:0]        now;
    } flare_t;

    typedef struct packed {
        logic [19:0] vx;
        logic [19:0] vy;
        logic [19:0] vz;
        logic [23:0] color;
        logic [7:0]  alpha;
        logic [1:0]  corner;
        logic        last;
    } corner_t;

    typedef struct {
        flare_t f;
        int     typed_alpha;
        bit     typed_cull;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [59:0]  cfg_data;

    flare_billboard_alpha_ramp u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // mirrored registers and alpha store
    logic        on_reg;
    logic [11:0] gain_reg;
    logic [59:0] eye_reg;
    logic [47:0] right_reg;
    logic [47:0] up_reg;
    logic [7:0]  alpha_mem [256];
    logic [31:0] tested_at [256];

    corner_t corner_q[$];
    int      mismatches;
    int      corners_seen;
    int      flares_sent;
    int      flares_culled;
    int      burst_left;
    logic    long_hold;
    int      cyc;
    logic [31:0] clock_ms;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void predict_quad(input flare_t f, output corner_t q[4], output int n);
        int          idx;
        longint      org[3], nrm[3], v[3], rt[3], upv[3];
        longint      dotn, negdot, fade, sz, ur, dr, p, t, r;
        longint unsigned d2, rem, res, bitv;
        logic [31:0] elapsed;
        int          a, aout;
        n = 0;
        if (!on_reg)
            return;
        idx = int'(f.idx);
        org[0] = longint'(f.ox); org[1] = longint'(f.oy); org[2] = longint'(f.oz);
        nrm[0] = longint'(f.nx); nrm[1] = longint'(f.ny); nrm[2] = longint'(f.nz);
        for (int i = 0; i < 3; i++)
        begin
            v[i]   = org[i] - longint'($signed(eye_reg[20*i +: 20]));
            rt[i]  = longint'($signed(right_reg[16*i +: 16]));
            upv[i] = longint'($signed(up_reg[16*i +: 16]));
        end
        elapsed = f.now - tested_at[idx];
        if (elapsed > fbar_pkg::TEST_MS)
        begin
            a = int'(alpha_mem[idx]);
            if (elapsed > fbar_pkg::STALE_MS)
                a = 0;
            a = f.vis ? a + 8 : a - 38;
            if (a > 192)
                a = 192;
            else if (a < 0)
                a = 0;
            alpha_mem[idx] = a[7:0];
            tested_at[idx] = f.now;
        end
        d2 = 0;
        dotn = 0;
        for (int i = 0; i < 3; i++)
        begin
            d2 += longint'(v[i] * v[i]);
            dotn += nrm[i] * v[i];
        end
        rem = d2;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        if (res == 0)
            dotn = 0;
        if (dotn > 0)
            return;
        negdot = (res != 0) ? (-dotn) / longint'(res) : 64'sd0;
        fade = longint'(fbar_pkg::FADE_BASE) + negdot * longint'(gain_reg);
        if (fade > longint'(fbar_pkg::FADE_ONE))
            fade = longint'(fbar_pkg::FADE_ONE);
        aout = int'((longint'(alpha_mem[idx]) * fade) >>> 22);
        sz = longint'(f.radius) + (longint'(f.radius) * longint'(res)) / 32000;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ur = (upv[i] + rt[i]) * sz;
                dr = (rt[i] - upv[i]) * sz;
                case (c)
                    0: p = org[i] * 16384 - dr;
                    1: p = org[i] * 16384 + ur;
                    2: p = org[i] * 16384 + dr;
                    default: p = org[i] * 16384 - ur;
                endcase
                t = p + 8192;
                r = t >>> 14;
                if (r > 524287)
                    r = 524287;
                if (r < -524288)
                    r = -524288;
                if (i == 0) q[c].vx = r[19:0];
                else if (i == 1) q[c].vy = r[19:0];
                else q[c].vz = r[19:0];
            end
            q[c].color  = f.color;
            q[c].alpha  = aout[7:0];
            q[c].corner = c[1:0];
            q[c].last   = (c == 3);
        end
        n = 4;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [59:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            fbar_pkg::CFG_FLARES_ON:   on_reg    = data[0];
            fbar_pkg::CFG_INTENSITY:   gain_reg  = data[11:0];
            fbar_pkg::CFG_VIEW_ORIGIN: eye_reg   = data;
            fbar_pkg::CFG_RIGHT_AXIS:  right_reg = data[47:0];
            fbar_pkg::CFG_UP_AXIS:     up_reg    = data[47:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (corner_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_flare(input flare_t f, input int typed_alpha, input bit typed_cull);
        corner_t q[4];
        int      n;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, f.now, f.vis, f.color, f.radius, f.nz, f.ny, f.nx,
                     f.oz, f.oy, f.ox, f.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        flares_sent++;
        predict_quad(f, q, n);
        if (typed_cull)
            n = 0;
        if (n == 0)
            flares_culled++;
        for (int c = 0; c < n; c++)
        begin
            if (typed_alpha >= 0)
                q[c].alpha = typed_alpha[7:0];
            corner_q.push_back(q[c]);
        end
    endtask

    function automatic flare_t random_flare(input bit wide);
        flare_t f;
        longint dot;
        f.idx = wide ? 8'($urandom) : 8'($urandom_range(0, 15));
        if (wide || $urandom_range(0, 7) == 0)
        begin
            f.ox = 20'($urandom);
            f.oy = 20'($urandom);
            f.oz = 20'($urandom);
        end
        else
        begin
            f.ox = $signed(eye_reg[19:0]) + $signed(20'($urandom_range(0, 8191)) - 20'sd4096);
            f.oy = $signed(eye_reg[39:20]) + $signed(20'($urandom_range(0, 8191)) - 20'sd4096);
            f.oz = $signed(eye_reg[59:40]) + $signed(20'($urandom_range(0, 8191)) - 20'sd4096);
        end
        f.nx = 16'($urandom_range(0, 32768)) - 16'sd16384;
        f.ny = 16'($urandom_range(0, 32768)) - 16'sd16384;
        f.nz = 16'($urandom_range(0, 32768)) - 16'sd16384;
        dot = longint'(f.nx) * (longint'(f.ox) - longint'($signed(eye_reg[19:0])))
            + longint'(f.ny) * (longint'(f.oy) - longint'($signed(eye_reg[39:20])))
            + longint'(f.nz) * (longint'(f.oz) - longint'($signed(eye_reg[59:40])));
        // flip most back-facing normals toward the viewer
        if (dot > 0 && $urandom_range(0, 4) != 0)
        begin
            f.nx = -f.nx;
            f.ny = -f.ny;
            f.nz = -f.nz;
        end
        f.radius = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
        f.color = 24'($urandom);
        f.vis = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 19))
            0: clock_ms = clock_ms + $urandom_range(501, 5000);
            1: clock_ms = clock_ms - $urandom_range(1, 100);
            2: clock_ms = $urandom;
            default: clock_ms = clock_ms + $urandom_range(0, 30);
        endcase
        f.now = clock_ms;
        return f;
    endfunction

    function automatic flare_t row(input int idx, input int ox, input int oy, input int oz,
                                   input int nx, input int ny, input int nz, input int rad,
                                   input int col, input bit vis, input logic [31:0] now);
        flare_t f;
        f.idx = idx[7:0]; f.ox = ox[19:0]; f.oy = oy[19:0]; f.oz = oz[19:0];
        f.nx = nx[15:0]; f.ny = ny[15:0]; f.nz = nz[15:0];
        f.radius = rad[15:0]; f.color = col[23:0]; f.vis = vis; f.now = now;
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            cyc <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (long_hold)
                m_tready <= 1'b0;
            else
                case (cyc[8:7])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                    2'd2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= cyc[2];
                endcase
        end
    end

    always @(posedge clk)
    begin
        corner_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.vx = m_tdata[19:0];
            got.vy = m_tdata[39:20];
            got.vz = m_tdata[59:40];
            got.color = m_tdata[83:60];
            got.alpha = m_tdata[91:84];
            got.corner = m_tuser;
            got.last = m_tlast;
            corners_seen++;
            if (corner_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected corner word: %p", got);
            end
            else
            begin
                want = corner_q.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("corner mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    initial
    begin
        long_hold = 1'b0;
        wait (flares_sent >= 120);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        on_reg = 1'b1;
        gain_reg = 12'd256;
        eye_reg = '0;
        right_reg = '0;
        up_reg = '0;
        for (int i = 0; i < 256; i++)
        begin
            alpha_mem[i] = '0;
            tested_at[i] = '0;
        end
        mismatches = 0;
        corners_seen = 0;
        flares_sent = 0;
        flares_culled = 0;
        burst_left = 0;
        clock_ms = $urandom;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ramp, hold, stale reset, hide, cull, zero distance, time wrap, extremes
        rows.push_back('{row(0, 16, 0, 0, -16384, 0, 0, 0, 24'h112233, 1, 100), 8, 0});
        rows.push_back('{row(0, 16, 0, 0, -16384, 0, 0, 0, 24'h112233, 1, 110), 8, 0});
        rows.push_back('{row(0, 16, 0, 0, -16384, 0, 0, 0, 24'h112233, 1, 131), 16, 0});
        rows.push_back('{row(0, 16, 0, 0, -16384, 0, 0, 0, 24'h112233, 1, 700), 8, 0});
        rows.push_back('{row(0, 16, 0, 0, -16384, 0, 0, 0, 24'h112233, 0, 730), 0, 0});
        rows.push_back('{row(0, 16, 0, 0, 16384, 0, 0, 0, 24'h445566, 1, 800), -1, 1});
        rows.push_back('{row(1, 0, 0, 0, 16384, 0, 0, 100, 24'hFFFFFF, 1, 100), 0, 0});
        rows.push_back('{row(2, 0, 0, 16, 0, 0, -16384, 5, 24'h0, 1, 32'hFFFFFFF0), 8, 0});
        rows.push_back('{row(2, 0, 0, 16, 0, 0, -16384, 5, 24'h0, 1, 5), 16, 0});
        rows.push_back('{row(255, 524287, 524287, 524287, -16384, -16384, -16384, 65535,
                             24'hFFFFFF, 1, 50), -1, 0});
        rows.push_back('{row(254, -524288, -524288, -524288, 16384, 16384, 16384, 65535,
                             24'hA5A5A5, 1, 60), -1, 0});
        rows.push_back('{row(3, -524288, 0, 524287, 16384, 0, -16384, 1, 24'h5A5A5A, 0, 40), -1, 0});
        rows.push_back('{row(4, 300, -200, 100, -9000, 6000, -3000, 200, 24'h00FF00, 1, 30), -1, 0});
        foreach (rows[i])
            send_flare(rows[i].f, rows[i].typed_alpha, rows[i].typed_cull);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(fbar_pkg::CFG_RIGHT_AXIS, 60'h000_0000_4000);
                    write_reg(fbar_pkg::CFG_UP_AXIS, 60'h000_4000_0000);
                    write_reg(fbar_pkg::CFG_INTENSITY, 60'd4095);
                    write_reg(CFG_UNUSED, '1);
                end
                1:
                begin
                    write_reg(fbar_pkg::CFG_VIEW_ORIGIN, 60'($urandom) | (60'($urandom) << 32));
                    write_reg(fbar_pkg::CFG_INTENSITY, 60'd0);
                end
                2:
                begin
                    write_reg(fbar_pkg::CFG_FLARES_ON, 60'd0);
                end
                3:
                begin
                    write_reg(fbar_pkg::CFG_FLARES_ON, 60'd1);
                    write_reg(fbar_pkg::CFG_RIGHT_AXIS, 60'({$urandom, $urandom}));
                    write_reg(fbar_pkg::CFG_UP_AXIS, 60'({$urandom, $urandom}));
                    write_reg(fbar_pkg::CFG_INTENSITY, 60'($urandom_range(0, 4095)));
                end
                4:
                begin
                    write_reg(fbar_pkg::CFG_VIEW_ORIGIN, {20'h7FFFF, 20'h80000, 20'h7FFFF});
                    write_reg(fbar_pkg::CFG_RIGHT_AXIS, 60'hC000_C000_C000);
                    write_reg(fbar_pkg::CFG_UP_AXIS, 60'h4000_C000_4000);
                end
                default:
                begin
                    write_reg(fbar_pkg::CFG_VIEW_ORIGIN, '0);
                    write_reg(fbar_pkg::CFG_INTENSITY, 60'd256);
                    write_reg(fbar_pkg::CFG_RIGHT_AXIS, 60'h0000_2D41_2D41);
                    write_reg(fbar_pkg::CFG_UP_AXIS, 60'h4000_0000_0000);
                end
            endcase
            repeat ((ph == 2) ? 20 : 85)
                send_flare(random_flare($urandom_range(0, 9) == 0), -1, 0);
            drain();
        end

        $display("covered %0d flares (%0d gave no quad), %0d corner words checked",
                 flares_sent, flares_culled, corners_seen);
        $display("config phases with extreme axes, origins, gains and output disabled");
        if (mismatches == 0 && corner_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
